// ----- hdl/duplex_frame_crc16_builder_checker_defines.svh -----
// Assertion macros used by the checker file of the duplex frame CRC-16 block.
`ifndef DUPLEX_FRAME_CRC16_BUILDER_CHECKER_DEFINES_SVH
`define DUPLEX_FRAME_CRC16_BUILDER_CHECKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DFCRC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("dfcrc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DFCRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("dfcrc assertion failed");

`endif

// ----- hdl/dfcrc_pkg.sv -----
// Types, constants and the CRC byte update for the duplex frame CRC-16 block.
package dfcrc_pkg;

	localparam int FRAME_LENGTH = 34;
	localparam int SLOT_W       = 6;
	localparam int BYTE_W       = 8;
	localparam int CRC_W        = 16;

	localparam logic [SLOT_W-1:0] HDR_FIRST_SLOT  = SLOT_W'(0);
	localparam logic [SLOT_W-1:0] HDR_SECOND_SLOT = SLOT_W'(1);
	localparam logic [SLOT_W-1:0] PAYLOAD_LAST    = SLOT_W'(FRAME_LENGTH - 4);
	localparam logic [SLOT_W-1:0] CRC_LO_SLOT     = SLOT_W'(FRAME_LENGTH - 3);
	localparam logic [SLOT_W-1:0] LAST_SLOT       = SLOT_W'(FRAME_LENGTH - 1);

	localparam logic [CRC_W-1:0]  CRC_POLY   = 16'hA001;
	localparam logic [CRC_W-1:0]  CRC_INIT   = 16'hFFFF;
	localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'd128;
	localparam logic [BYTE_W-1:0] HDR_SECOND = 8'd255;
	localparam logic [BYTE_W-1:0] TRAILER    = 8'd128;

	typedef struct packed {
		logic [BYTE_W-1:0] tx_payload_byte;
		logic [BYTE_W-1:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] tx_byte;
		logic [SLOT_W-1:0] slot_index;
		logic [BYTE_W-1:0] rx_payload_byte;
		logic              rx_payload_valid;
		logic              frame_last;
		logic              crc_ok;
	} out_item_t;

	// Reflected CRC-16 over one byte, least significant bit first.
	function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] acc,
			input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = acc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
		for (int k = 0; k < BYTE_W; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ----- hdl/dfcrc_core.sv -----
// Slot sequencer, CRC accumulators and per-slot result logic.
module dfcrc_core
	import dfcrc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      advance,
	input  in_item_t  item,
	output out_item_t result
);

	logic [SLOT_W-1:0] slot_q, slot_d;
	logic [CRC_W-1:0]  tx_crc_q, tx_crc_d;
	logic [CRC_W-1:0]  rx_crc_q, rx_crc_d;
	logic [BYTE_W-1:0] rx_lo_q, rx_lo_d;
	logic [BYTE_W-1:0] rx_hi_q, rx_hi_d;

	always_comb begin
		result            = '0;
		result.slot_index = slot_q;
		tx_crc_d          = tx_crc_q;
		rx_crc_d          = rx_crc_q;
		rx_lo_d           = rx_lo_q;
		rx_hi_d           = rx_hi_q;
		slot_d            = slot_q + SLOT_W'(1);
		priority if (slot_q >= LAST_SLOT) begin
			result.tx_byte    = TRAILER;
			result.frame_last = 1'b1;
			result.crc_ok     = ({rx_hi_q, rx_lo_q} == rx_crc_q);
			slot_d            = '0;
			tx_crc_d          = CRC_INIT;
			rx_crc_d          = CRC_INIT;
		end else if (slot_q == HDR_FIRST_SLOT) begin
			result.tx_byte = HDR_FIRST;
		end else if (slot_q == HDR_SECOND_SLOT) begin
			result.tx_byte = HDR_SECOND;
		end else if (slot_q <= PAYLOAD_LAST) begin
			result.tx_byte          = item.tx_payload_byte;
			result.rx_payload_byte  = item.rx_byte;
			result.rx_payload_valid = 1'b1;
			tx_crc_d = crc_byte(tx_crc_q, item.tx_payload_byte);
			rx_crc_d = crc_byte(rx_crc_q, item.rx_byte);
		end else if (slot_q == CRC_LO_SLOT) begin
			result.tx_byte = tx_crc_q[BYTE_W-1:0];
			rx_lo_d        = item.rx_byte;
		end else begin
			result.tx_byte = tx_crc_q[CRC_W-1:BYTE_W];
			rx_hi_d        = item.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q   <= '0;
			tx_crc_q <= CRC_INIT;
			rx_crc_q <= CRC_INIT;
			rx_lo_q  <= '0;
			rx_hi_q  <= '0;
		end else if (advance) begin
			slot_q   <= slot_d;
			tx_crc_q <= tx_crc_d;
			rx_crc_q <= rx_crc_d;
			rx_lo_q  <= rx_lo_d;
			rx_hi_q  <= rx_hi_d;
		end
	end

endmodule

// ----- hdl/duplex_frame_crc16_builder_checker.sv -----
// Top level of the duplex frame CRC-16 builder and checker.
// Each accepted item is one byte slot of a full-duplex frame of FRAME_LENGTH
// slots (34 here), and each item yields exactly one result item. The block
// sends 128 and 255 as header, the payload bytes, the low and then the high
// byte of the reflected CRC-16 (polynomial 0xA001, start 0xFFFF) over the sent
// payload, and 128 as trailer; in parallel it runs the same CRC over the
// received payload, passes received payload bytes out and raises crc_ok on
// the last slot when the received CRC matches. The block takes one item per
// clock cycle while it is not stalled. Each item is held in the input register;
// the slot logic and the unrolled eight-step CRC byte update sit between that
// register and the result register, which loads the result when the item leaves
// the input register. The block holds at most two items; the input stalls only
// while the input register is full and the result register is stalled.
module duplex_frame_crc16_builder_checker
	import dfcrc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result
);

	logic      valid_s1;
	in_item_t  item_s1;
	logic      advance;
	logic      result_valid_q;
	out_item_t result_q;
	out_item_t result_d;

	// An item leaves the input register when the result register is empty
	// or its item is being taken in this same cycle.
	assign advance    = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	// The frame state moves forward only when an item crosses into the
	// result register, so a stall never repeats or skips a slot.
	dfcrc_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.result  (result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ----- hdl/dfcrc_checker.sv -----
// Port-level checker for the duplex frame CRC-16 block, bound to its top level.
`include "duplex_frame_crc16_builder_checker_defines.svh"

module dfcrc_checker
	import dfcrc_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      item_valid,
	input logic      item_stall,
	input in_item_t  item,
	input logic      result_valid,
	input logic      result_stall,
	input out_item_t result
);

	logic [SLOT_W-1:0] exp_slot_q;
	logic              taken;
	logic              in_wait;
	logic              out_wait;

	assign taken    = result_valid && !result_stall;
	assign in_wait  = item_valid && item_stall;
	assign out_wait = result_valid && result_stall;

	// Tracks the slot that the next delivered item must carry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_slot_q <= '0;
		end else if (taken) begin
			exp_slot_q <= result.frame_last ? '0 : result.slot_index + SLOT_W'(1);
		end
	end

	`DFCRC_ASSERT_NEXT(a_result_holds, clk, arst_n, out_wait, result_valid && $stable(result))
	`DFCRC_ASSERT_NEXT(a_item_holds, clk, arst_n, in_wait, item_valid && $stable(item))
	`DFCRC_ASSERT_NOW(a_stall_only_full, clk, arst_n, item_stall, out_wait)
	`DFCRC_ASSERT_NOW(a_slot_order, clk, arst_n, result_valid, result.slot_index == exp_slot_q)
	`DFCRC_ASSERT_NOW(a_ok_on_last, clk, arst_n, result_valid && result.crc_ok, result.frame_last)

endmodule

bind duplex_frame_crc16_builder_checker dfcrc_checker u_dfcrc_checker (.*);
